FILE: hw/rtl/alu8f_pkg.sv
// Package for the 8-bit CPU ALU: operation codes and field widths.
`default_nettype none

package alu8f_pkg;

  localparam int unsigned CMD_W  = 5;
  localparam int unsigned WORD_W = 16;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned FLAG_W = 4;

  // Flag bit positions inside a flags nibble.
  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 24;

  // Codes 20 to 31 are not listed and act as a no-op.
  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 5'd0,
    CMD_ADC    = 5'd1,
    CMD_SUB    = 5'd2,
    CMD_SBC    = 5'd3,
    CMD_AND    = 5'd4,
    CMD_XOR    = 5'd5,
    CMD_OR     = 5'd6,
    CMD_CP     = 5'd7,
    CMD_INC    = 5'd8,
    CMD_DEC    = 5'd9,
    CMD_DAA    = 5'd10,
    CMD_CPL    = 5'd11,
    CMD_SCF    = 5'd12,
    CMD_CCF    = 5'd13,
    CMD_RLCA   = 5'd14,
    CMD_RLA    = 5'd15,
    CMD_RRCA   = 5'd16,
    CMD_RRA    = 5'd17,
    CMD_ADD16  = 5'd18,
    CMD_ADD_SP = 5'd19
  } cmd_t;

endpackage

`default_nettype wire

FILE: hw/rtl/cpu_alu_8bit_flags_core.sv
// Top level of the 8-bit CPU ALU: a three-stage pipelined operation unit.
//
// Usage:
//   The input channel (in_*) carries one request per operation: the opcode
//   in in_tuser, the two operands and the incoming Z N H C flags in in_tdata.
//   The output channel (out_*) returns one result per operation: the new
//   value and the new flags. Results leave in the order requests came in.
// Pipeline:
//   An accepted request passes through the stage one, stage two and output
//   registers in turn and is offered on out_tvalid from the last. Stage
//   one registers the request and works out the decimal adjust correction,
//   stage two runs all adders side by side, stage three selects the result
//   and forms the flags into the output register. While out_tready is high,
//   one request can be accepted in every cycle: one per clock, sustained.
// Reset:
//   rst_n is synchronous and active low. It empties all three stages; the
//   block holds no other state, and in_tready is high right after reset.
// Stalls:
//   When out_tready is low the output register holds its request, and each
//   stage behind it moves only into a free slot. in_tready drops once every
//   stage holds a request, so nothing is lost or repeated.
`default_nettype none

module cpu_alu_8bit_flags_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // in_tdata from bit 0 up: operand_a[15:0], operand_b[15:0], flags_in[3:0],
  // then zero padding.
  input  wire logic [alu8f_pkg::IN_TDATA_W-1:0]  in_tdata,
  // in_tuser from bit 0 up: cmd[4:0].
  input  wire logic [alu8f_pkg::CMD_W-1:0]       in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // out_tdata from bit 0 up: result_value[15:0], flags_out[3:0], then zeros.
  output logic [alu8f_pkg::OUT_TDATA_W-1:0]      out_tdata
);

  import alu8f_pkg::*;

  // ---------------------------------------------------------------------
  // Stage advance: each stage loads when it is empty or the next one moves.
  // ---------------------------------------------------------------------
  logic ld1, ld2, ld3;
  logic v1_r, v2_r, vo_r;

  assign ld3       = !vo_r || out_tready;
  assign ld2       = !v2_r || ld3;
  assign ld1       = !v1_r || ld2;
  assign in_tready = ld1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (ld1) begin
        v1_r <= in_tvalid;
      end
      if (ld2) begin
        v2_r <= v1_r;
      end
      if (ld3) begin
        vo_r <= v2_r;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: unpack the request and work out the decimal adjust correction.
  // ---------------------------------------------------------------------
  logic [WORD_W-1:0] in_a, in_b;
  logic [FLAG_W-1:0] in_f;
  logic [BYTE_W-1:0] daa_corr_nxt;
  logic              daa_cy_nxt;
  logic              daa_hi, daa_lo;

  assign in_a = in_tdata[WORD_W-1:0];
  assign in_b = in_tdata[2*WORD_W-1:WORD_W];
  assign in_f = in_tdata[2*WORD_W+FLAG_W-1:2*WORD_W];

  always_comb begin
    // After an add the correction depends on the digits; after a subtract
    // only on the incoming half and full carries.
    if (!in_f[FLAG_N]) begin
      daa_hi     = in_f[FLAG_C] || (in_a[7:0] > 8'h99);
      daa_lo     = in_f[FLAG_H] || (in_a[3:0] > 4'h9);
      daa_cy_nxt = daa_hi ? 1'b1 : in_f[FLAG_C];
    end else begin
      daa_hi     = in_f[FLAG_C];
      daa_lo     = in_f[FLAG_H];
      daa_cy_nxt = in_f[FLAG_C];
    end
    daa_corr_nxt = (daa_hi ? 8'h60 : 8'h00) | (daa_lo ? 8'h06 : 8'h00);
  end

  cmd_t              cmd1_r;
  logic [WORD_W-1:0] a1_r, b1_r;
  logic [FLAG_W-1:0] f1_r;
  logic [BYTE_W-1:0] dcorr1_r;
  logic              dcy1_r;

  always_ff @(posedge clk) begin
    if (ld1) begin
      cmd1_r   <= cmd_t'(in_tuser);
      a1_r     <= in_a;
      b1_r     <= in_b;
      f1_r     <= in_f;
      dcorr1_r <= daa_corr_nxt;
      dcy1_r   <= daa_cy_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: all adders in parallel; stage 3 picks the one it needs.
  // ---------------------------------------------------------------------
  logic              cadd, csub;
  logic [8:0]        add9_nxt, sub9_nxt;
  logic [4:0]        hadd_nxt, hsub_nxt;
  logic [BYTE_W-1:0] inc8_nxt, dec8_nxt, daa8_nxt;
  logic [WORD_W:0]   add16_nxt;
  logic [12:0]       h12_nxt;
  logic [WORD_W-1:0] sp16_nxt;

  always_comb begin
    cadd      = (cmd1_r == CMD_ADC) ? f1_r[FLAG_C] : 1'b0;
    csub      = (cmd1_r == CMD_SBC) ? f1_r[FLAG_C] : 1'b0;
    add9_nxt  = {1'b0, a1_r[7:0]} + {1'b0, b1_r[7:0]} + {8'h00, cadd};
    hadd_nxt  = {1'b0, a1_r[3:0]} + {1'b0, b1_r[3:0]} + {4'h0, cadd};
    sub9_nxt  = {1'b0, a1_r[7:0]} - {1'b0, b1_r[7:0]} - {8'h00, csub};
    hsub_nxt  = {1'b0, a1_r[3:0]} - {1'b0, b1_r[3:0]} - {4'h0, csub};
    inc8_nxt  = a1_r[7:0] + 8'h01;
    dec8_nxt  = a1_r[7:0] - 8'h01;
    daa8_nxt  = f1_r[FLAG_N] ? (a1_r[7:0] - dcorr1_r) : (a1_r[7:0] + dcorr1_r);
    add16_nxt = {1'b0, a1_r} + {1'b0, b1_r};
    h12_nxt   = {1'b0, a1_r[11:0]} + {1'b0, b1_r[11:0]};
    sp16_nxt  = a1_r + {{(WORD_W-BYTE_W){b1_r[7]}}, b1_r[7:0]};
  end

  cmd_t              cmd2_r;
  logic [WORD_W-1:0] a2_r;
  logic [BYTE_W-1:0] b2_r;
  logic [FLAG_W-1:0] f2_r;
  logic              dcy2_r;
  logic [8:0]        add9_r, sub9_r;
  logic              hadd_r, hsub_r;
  logic [BYTE_W-1:0] inc8_r, dec8_r, daa8_r;
  logic [WORD_W:0]   add16_r;
  logic              h12_r;
  logic [WORD_W-1:0] sp16_r;

  always_ff @(posedge clk) begin
    if (ld2) begin
      cmd2_r  <= cmd1_r;
      a2_r    <= a1_r;
      b2_r    <= b1_r[7:0];
      f2_r    <= f1_r;
      dcy2_r  <= dcy1_r;
      add9_r  <= add9_nxt;
      sub9_r  <= sub9_nxt;
      hadd_r  <= hadd_nxt[4];
      hsub_r  <= hsub_nxt[4];
      inc8_r  <= inc8_nxt;
      dec8_r  <= dec8_nxt;
      daa8_r  <= daa8_nxt;
      add16_r <= add16_nxt;
      h12_r   <= h12_nxt[12];
      sp16_r  <= sp16_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: select the value, form the flags, load the output register.
  // ---------------------------------------------------------------------
  logic [WORD_W-1:0] res_nxt;
  logic [FLAG_W-1:0] flg_nxt;
  logic [BYTE_W-1:0] a8, zsrc;
  logic              zf;

  assign a8 = a2_r[7:0];

  always_comb begin
    res_nxt = a2_r;
    flg_nxt = f2_r;
    zsrc    = 8'h00;
    case (cmd2_r)
      CMD_ADD, CMD_ADC: begin
        zsrc = add9_r[7:0];
      end
      CMD_SUB, CMD_SBC, CMD_CP: begin
        zsrc = sub9_r[7:0];
      end
      CMD_AND: begin
        zsrc = a8 & b2_r;
      end
      CMD_XOR: begin
        zsrc = a8 ^ b2_r;
      end
      CMD_OR: begin
        zsrc = a8 | b2_r;
      end
      CMD_INC: begin
        zsrc = inc8_r;
      end
      CMD_DEC: begin
        zsrc = dec8_r;
      end
      CMD_DAA: begin
        zsrc = daa8_r;
      end
      default: begin
        zsrc = a8;
      end
    endcase
    zf = (zsrc == 8'h00);

    case (cmd2_r)
      CMD_ADD, CMD_ADC: begin
        res_nxt = {8'h00, add9_r[7:0]};
        flg_nxt = {zf, 1'b0, hadd_r, add9_r[8]};
      end
      CMD_SUB, CMD_SBC: begin
        res_nxt = {8'h00, sub9_r[7:0]};
        flg_nxt = {zf, 1'b1, hsub_r, sub9_r[8]};
      end
      CMD_CP: begin
        res_nxt = a2_r;
        flg_nxt = {zf, 1'b1, hsub_r, sub9_r[8]};
      end
      CMD_AND: begin
        res_nxt = {8'h00, zsrc};
        flg_nxt = {zf, 1'b0, 1'b1, 1'b0};
      end
      CMD_XOR, CMD_OR: begin
        res_nxt = {8'h00, zsrc};
        flg_nxt = {zf, 3'b000};
      end
      CMD_INC: begin
        res_nxt = {8'h00, inc8_r};
        flg_nxt = {zf, 1'b0, (a8[3:0] == 4'hF), f2_r[FLAG_C]};
      end
      CMD_DEC: begin
        res_nxt = {8'h00, dec8_r};
        flg_nxt = {zf, 1'b1, (a8[3:0] == 4'h0), f2_r[FLAG_C]};
      end
      CMD_DAA: begin
        res_nxt = {8'h00, daa8_r};
        flg_nxt = {zf, f2_r[FLAG_N], 1'b0, dcy2_r};
      end
      CMD_CPL: begin
        res_nxt = {8'h00, ~a8};
        flg_nxt = {f2_r[FLAG_Z], 1'b1, 1'b1, f2_r[FLAG_C]};
      end
      CMD_SCF: begin
        res_nxt = a2_r;
        flg_nxt = {f2_r[FLAG_Z], 2'b00, 1'b1};
      end
      CMD_CCF: begin
        res_nxt = a2_r;
        flg_nxt = {f2_r[FLAG_Z], 2'b00, ~f2_r[FLAG_C]};
      end
      CMD_RLCA: begin
        res_nxt = {8'h00, a8[6:0], a8[7]};
        flg_nxt = {3'b000, a8[7]};
      end
      CMD_RLA: begin
        res_nxt = {8'h00, a8[6:0], f2_r[FLAG_C]};
        flg_nxt = {3'b000, a8[7]};
      end
      CMD_RRCA: begin
        res_nxt = {8'h00, a8[0], a8[7:1]};
        flg_nxt = {3'b000, a8[0]};
      end
      CMD_RRA: begin
        res_nxt = {8'h00, f2_r[FLAG_C], a8[7:1]};
        flg_nxt = {3'b000, a8[0]};
      end
      CMD_ADD16: begin
        res_nxt = add16_r[WORD_W-1:0];
        flg_nxt = {f2_r[FLAG_Z], 1'b0, h12_r, add16_r[WORD_W]};
      end
      CMD_ADD_SP: begin
        // Flags come from the unsigned low-byte add, which carries no C in.
        res_nxt = sp16_r;
        flg_nxt = {2'b00, hadd_r, add9_r[8]};
      end
      default: begin
        res_nxt = a2_r;
        flg_nxt = f2_r;
      end
    endcase
  end

  logic [WORD_W-1:0] res_r;
  logic [FLAG_W-1:0] flg_r;

  always_ff @(posedge clk) begin
    if (ld3) begin
      res_r <= res_nxt;
      flg_r <= flg_nxt;
    end
  end

  assign out_tvalid = vo_r;
  assign out_tdata  = {{(OUT_TDATA_W-WORD_W-FLAG_W){1'b0}}, flg_r, res_r};

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // An accepted request always lands in stage one.
  a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> v1_r)
    else $error("accepted request did not enter stage one");

  // A held request in stage two is not dropped while the output stalls.
  a_s2_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !ld3) |=> (v2_r && $stable(res_nxt)))
    else $error("stage two request lost during a stall");

  // An empty pipeline never refuses a request.
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (!v1_r && !v2_r && !vo_r) |-> in_tready)
    else $error("in_tready low with the pipeline empty");

  // Byte-wide arithmetic leaves the high byte of the result clear.
  a_high_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && ld3 && (cmd2_r == CMD_ADD || cmd2_r == CMD_ADC || cmd2_r == CMD_SUB ||
     cmd2_r == CMD_SBC || cmd2_r == CMD_INC || cmd2_r == CMD_DEC ||
     cmd2_r == CMD_DAA)) |=> (out_tdata[15:8] == 8'h00))
    else $error("byte operation produced a nonzero high byte");

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for the pipelined 8-bit CPU ALU with flag outputs.
`timescale 1ns / 1ps

module testbench;
  import alu8f_pkg::*;

  // Opcodes 20 to 31 have no name in the package. They must pass
  // operand_a and the flags through unchanged.
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 5'd20;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 5'd31;

  // Single-flag masks, used to build the flag nibbles of the directed requests.
  localparam logic [FLAG_W-1:0] FL_Z = 4'b1000;
  localparam logic [FLAG_W-1:0] FL_N = 4'b0100;
  localparam logic [FLAG_W-1:0] FL_H = 4'b0010;
  localparam logic [FLAG_W-1:0] FL_C = 4'b0001;

  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic [FLAG_W-1:0] flags;
  } alu_result_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [CMD_W-1:0]       in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  alu_result_t pending_results[$];
  int          error_count   = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          stall_cycles  = 0;

  cpu_alu_8bit_flags_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Computes the value and flags that the ALU should produce for one request.
  function automatic alu_result_t alu_outcome(logic [CMD_W-1:0] op, logic [WORD_W-1:0] a16,
                                              logic [WORD_W-1:0] b16,
                                              logic [FLAG_W-1:0] fin);
    logic [7:0]        a;
    logic [7:0]        b;
    logic [7:0]        r8;
    logic              cin;
    logic              cy;
    logic [8:0]        sum9;
    logic [4:0]        nib5;
    logic [12:0]       sum13;
    logic [16:0]       sum17;
    logic [WORD_W-1:0] r;
    logic [FLAG_W-1:0] f;
    a   = a16[7:0];
    b   = b16[7:0];
    cin = fin[FLAG_C];
    r   = a16;
    f   = fin;
    case (cmd_t'(op))
      CMD_ADD, CMD_ADC: begin
        cy   = (op == CMD_ADC) ? cin : 1'b0;
        sum9 = {1'b0, a} + {1'b0, b} + {8'h00, cy};
        nib5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, cy};
        r    = {8'h00, sum9[7:0]};
        f    = '0;
        f[FLAG_Z] = (sum9[7:0] == 8'h00);
        f[FLAG_H] = nib5[4];
        f[FLAG_C] = sum9[8];
      end
      CMD_SUB, CMD_SBC, CMD_CP: begin
        // Compare sets the flags exactly as subtract does but keeps operand_a.
        cy   = (op == CMD_SBC) ? cin : 1'b0;
        r8   = a - b - {7'h00, cy};
        nib5 = {1'b0, b[3:0]} + {4'h0, cy};
        sum9 = {1'b0, b} + {8'h00, cy};
        f    = '0;
        f[FLAG_Z] = (r8 == 8'h00);
        f[FLAG_N] = 1'b1;
        f[FLAG_H] = nib5 > {1'b0, a[3:0]};
        f[FLAG_C] = sum9 > {1'b0, a};
        r = (op == CMD_CP) ? a16 : {8'h00, r8};
      end
      CMD_AND: begin
        r8 = a & b;
        r  = {8'h00, r8};
        f  = FL_H;
        f[FLAG_Z] = (r8 == 8'h00);
      end
      CMD_XOR, CMD_OR: begin
        r8 = (op == CMD_XOR) ? (a ^ b) : (a | b);
        r  = {8'h00, r8};
        f  = '0;
        f[FLAG_Z] = (r8 == 8'h00);
      end
      CMD_INC: begin
        r8 = a + 8'h01;
        r  = {8'h00, r8};
        f  = '0;
        f[FLAG_Z] = (r8 == 8'h00);
        f[FLAG_H] = (a[3:0] == 4'hF);
        f[FLAG_C] = cin;
      end
      CMD_DEC: begin
        r8 = a - 8'h01;
        r  = {8'h00, r8};
        f  = FL_N;
        f[FLAG_Z] = (r8 == 8'h00);
        f[FLAG_H] = (a[3:0] == 4'h0);
        f[FLAG_C] = cin;
      end
      CMD_DAA: begin
        // The direction of the correction comes from N of the previous operation.
        cy = cin;
        r8 = a;
        if (!fin[FLAG_N]) begin
          if (cin || a > 8'h99) begin
            r8 = r8 + 8'h60;
            cy = 1'b1;
          end
          if (fin[FLAG_H] || a[3:0] > 4'h9) r8 = r8 + 8'h06;
        end else begin
          if (cin) r8 = r8 - 8'h60;
          if (fin[FLAG_H]) r8 = r8 - 8'h06;
        end
        r = {8'h00, r8};
        f = '0;
        f[FLAG_Z] = (r8 == 8'h00);
        f[FLAG_N] = fin[FLAG_N];
        f[FLAG_C] = cy;
      end
      CMD_CPL: begin
        r = {8'h00, ~a};
        f = (fin & (FL_Z | FL_C)) | FL_N | FL_H;
      end
      CMD_SCF: begin
        f = (fin & FL_Z) | FL_C;
      end
      CMD_CCF: begin
        f = fin & FL_Z;
        f[FLAG_C] = ~cin;
      end
      CMD_RLCA, CMD_RLA: begin
        cy = (op == CMD_RLCA) ? a[7] : cin;
        r  = {8'h00, a[6:0], cy};
        f  = '0;
        f[FLAG_C] = a[7];
      end
      CMD_RRCA, CMD_RRA: begin
        cy = (op == CMD_RRCA) ? a[0] : cin;
        r  = {8'h00, cy, a[7:1]};
        f  = '0;
        f[FLAG_C] = a[0];
      end
      CMD_ADD16: begin
        sum17 = {1'b0, a16} + {1'b0, b16};
        sum13 = {1'b0, a16[11:0]} + {1'b0, b16[11:0]};
        r = sum17[15:0];
        f = fin & FL_Z;
        f[FLAG_H] = sum13[12];
        f[FLAG_C] = sum17[16];
      end
      CMD_ADD_SP: begin
        // The byte is sign extended for the value, but the flags come from
        // the unsigned add of the two low bytes.
        r    = a16 + {{8{b[7]}}, b};
        nib5 = {1'b0, a[3:0]} + {1'b0, b[3:0]};
        sum9 = {1'b0, a} + {1'b0, b};
        f    = '0;
        f[FLAG_H] = nib5[4];
        f[FLAG_C] = sum9[8];
      end
      default: begin
        r = a16;
        f = fin;
      end
    endcase
    return '{value: r, flags: f};
  endfunction

  // Offers one request and returns once the ALU has taken it. The expected
  // outcome is queued at the edge at which the request is accepted.
  task automatic send_op(logic [CMD_W-1:0] op, logic [WORD_W-1:0] a16,
                         logic [WORD_W-1:0] b16, logic [FLAG_W-1:0] fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'h0, fin, b16, a16};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(alu_outcome(op, a16, b16, fin));
  endtask

  // Operands that favor the carry corners and BCD digits now and then.
  function automatic logic [WORD_W-1:0] pick_operand();
    case ($urandom_range(3))
      0: return {8'($urandom), 4'($urandom_range(9)), 4'($urandom_range(9))};
      1: begin
        case ($urandom_range(5))
          0:       return 16'h0000;
          1:       return 16'hFFFF;
          2:       return 16'h00FF;
          3:       return 16'h0FFF;
          4:       return 16'h8080;
          default: return 16'h7F0F;
        endcase
      end
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_directed_cases();
    send_op(CMD_ADD,    16'h00FF, 16'h0001, 4'h0);
    send_op(CMD_ADD,    16'hAB12, 16'hCD34, 4'hF);
    send_op(CMD_ADC,    16'h000F, 16'h0000, FL_C);
    send_op(CMD_ADC,    16'h00FF, 16'h00FF, FL_C);
    send_op(CMD_SUB,    16'h0042, 16'h0042, 4'h0);
    send_op(CMD_SBC,    16'h0000, 16'h0000, FL_C);
    send_op(CMD_SUB,    16'h0010, 16'h0001, 4'h0);
    send_op(CMD_AND,    16'hFFFF, 16'hFF00, 4'h0);
    send_op(CMD_XOR,    16'h005A, 16'h005A, 4'h0);
    send_op(CMD_OR,     16'h0000, 16'h0080, 4'hF);
    send_op(CMD_CP,     16'hFF3C, 16'h003C, 4'h0);
    send_op(CMD_INC,    16'h00FF, 16'h0000, FL_C);
    send_op(CMD_DEC,    16'h0000, 16'h0000, 4'h0);
    // Decimal adjust after an add that needs both corrections and wraps to zero.
    send_op(CMD_DAA,    16'h009A, 16'h0000, 4'h0);
    // Decimal adjust after a subtract with both borrows set.
    send_op(CMD_DAA,    16'h0015, 16'h0000, FL_N | FL_H | FL_C);
    send_op(CMD_CPL,    16'h0055, 16'h0000, FL_Z | FL_C);
    send_op(CMD_SCF,    16'hFFFF, 16'h0000, FL_N | FL_H);
    send_op(CMD_CCF,    16'h1234, 16'h0000, FL_Z | FL_C);
    send_op(CMD_RLCA,   16'h0080, 16'h0000, FL_Z);
    send_op(CMD_RLA,    16'h007F, 16'h0000, FL_C);
    send_op(CMD_RRCA,   16'h0001, 16'h0000, FL_Z);
    send_op(CMD_RRA,    16'h00FE, 16'h0000, FL_C);
    send_op(CMD_ADD16,  16'h0FFF, 16'h0001, FL_Z);
    send_op(CMD_ADD16,  16'hFFFF, 16'hFFFF, 4'h0);
    send_op(CMD_ADD_SP, 16'hFFFF, 16'h0001, 4'hF);
    send_op(CMD_ADD_SP, 16'h0000, 16'h00FF, 4'h0);
    send_op(CMD_SPARE_LO, 16'hFFFF, 16'hFFFF, 4'hA);
    send_op(CMD_SPARE_HI, 16'h0000, 16'h0000, 4'h5);
  endtask

  task automatic test_random_ops(int count, int send_pct, int recv_pct);
    logic [CMD_W-1:0] op;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) begin
      if ($urandom_range(9) == 0) op = 5'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
      else op = 5'($urandom_range(CMD_ADD, CMD_ADD_SP));
      send_op(op, pick_operand(), pick_operand(), 4'($urandom));
    end
  endtask

  // The receiver holds off for a long stretch while requests keep coming,
  // so all pipeline stages fill and in_tready has to drop.
  task automatic test_output_stall();
    send_idle_pct = 0;
    stall_cycles  = 60;
    repeat (20) send_op(5'($urandom_range(CMD_ADD, CMD_ADD_SP)), pick_operand(),
                        pick_operand(), 4'($urandom));
  endtask

  // Result side: out_tready is redrawn on every edge unless a stall is running.
  always @(posedge clk) begin
    if (stall_cycles > 0) begin
      out_tready   <= 1'b0;
      stall_cycles <= stall_cycles - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_results
    alu_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request pending: out_tdata %h", out_tdata);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[15:0] !== want.value) begin
          $error("result_value: expected %h, got %h", want.value, out_tdata[15:0]);
          error_count++;
        end
        if (out_tdata[19:16] !== want.flags) begin
          $error("flags_out: expected %b, got %b", want.flags, out_tdata[19:16]);
          error_count++;
        end
        if (out_tdata[OUT_TDATA_W-1:20] !== '0) begin
          $error("padding: expected 0, got %h", out_tdata[OUT_TDATA_W-1:20]);
          error_count++;
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_random_ops(220, 37, 65);
    test_output_stall();
    test_random_ops(220, 65, 37);
    test_random_ops(220, 0, 0);

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
